// File: hw/rtl/mftp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mftp_pkg: shared constants for the FIR tap predictor
// Parameter memory layout, fixed-point helpers and controller codes.
// ---------------------------------------------------------------------------
package mftp_pkg;
	localparam int HiddenUnits = 16;
	localparam int ParamDepth  = 512;
	localparam int AddrW       = $clog2(ParamDepth);
	localparam int CntW        = $clog2(HiddenUnits + 1);

	localparam int W0Base   = 0;
	localparam int B0Base   = W0Base + 3 * HiddenUnits;
	localparam int W1Base   = B0Base + HiddenUnits;
	localparam int B1Base   = W1Base + HiddenUnits * HiddenUnits;
	localparam int W2Base   = B1Base + HiddenUnits;
	localparam int B2Base   = W2Base + 3 * HiddenUnits;
	localparam int MeanBase = B2Base + 3;
	localparam int RstdBase = MeanBase + 3;

	localparam logic [30:0] MinGainReset = 31'd655;

	// Command kinds
	localparam logic KindLoad    = 1'b0;
	localparam logic KindPredict = 1'b1;

	// Signed saturation of a 64-bit value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) return 32'sh7FFF_FFFF;
		else if (v < lo) return 32'sh8000_0000;
		else return v[31:0];
	endfunction

	// Saturating add of two Q16.16 words
	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] s;
		s = 64'(a) + 64'(b);
		return sat32(s);
	endfunction

	// Arithmetic shift gives floor; then saturate
	function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p >>> 16;
		return sat32(s);
	endfunction
endpackage

// File: hw/rtl/mlp_fir_tap_predictor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlp_fir_tap_predictor: 3-16-16-3 ReLU network predicting FIR taps
// One shared multiply-accumulate walks a parameter RAM and a hidden RAM.
// ---------------------------------------------------------------------------
// channel   direction  handshake              payload
// command   in         start & !busy          kind, param_addr, param_value,
//                                             centroid, level_rms, crest
// result    out        strobe (one cycle)     tap0..tap2, gain_normalized
// config    in         cfg_valid & cfg_ready  cfg_data (31 bits)
//
// A load writes the parameter RAM; busy stays low. A predict keeps busy high
// until the result: each of the 352 multiply-accumulates is a weight read, a
// multiply and an accumulate; each feature is a mean read, an rstd read with
// subtract and a multiply, each unit a bias read, bias wait and store; then
// the tap sum, three divides if the sum passes the threshold, and the output.
// Reset clears control state and sets the threshold to 655. Results cannot
// be stalled; busy falls in the cycle the result strobe is high.
// ---------------------------------------------------------------------------
module mlp_fir_tap_predictor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [8:0]  param_addr,
	input  logic signed [31:0] param_value,
	input  logic signed [31:0] centroid,
	input  logic signed [31:0] level_rms,
	input  logic signed [31:0] crest,
	output logic        strobe,
	output logic signed [31:0] tap0,
	output logic signed [31:0] tap1,
	output logic signed [31:0] tap2,
	output logic        gain_normalized,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data
);
	import mftp_pkg::*;

	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StFeatA = 4'd1; // read mean
	localparam logic [3:0] StFeatB = 4'd2; // read rstd, subtract
	localparam logic [3:0] StFeatC = 4'd3; // multiply
	localparam logic [3:0] StBias  = 4'd4; // read bias
	localparam logic [3:0] StWt    = 4'd5; // read weight and activation
	localparam logic [3:0] StMul   = 4'd6;
	localparam logic [3:0] StAcc   = 4'd7;
	localparam logic [3:0] StStore = 4'd8;
	localparam logic [3:0] StSum   = 4'd9;
	localparam logic [3:0] StDiv   = 4'd10;
	localparam logic [3:0] StDivW  = 4'd11;
	localparam logic [3:0] StOut   = 4'd12;
	localparam logic [3:0] StBiasW = 4'd13;

	logic [3:0]  state_q;
	logic [1:0]  layer_q;   // 0,1,2 dense layers
	logic [CntW-1:0] unit_q;
	logic [CntW-1:0] in_q;
	logic [1:0]  fj_q;
	logic [30:0] min_gain_q;
	logic signed [31:0] x_q [3];
	logic signed [31:0] feat_q [3];
	logic signed [31:0] tap_q [3];
	logic signed [31:0] acc_q;
	logic signed [31:0] diff_q;
	logic signed [63:0] prod_q;
	logic        norm_q;
	logic signed [31:0] sum_q;

	// Parameter RAM port
	logic              p_we;
	logic [AddrW-1:0]  p_addr;
	logic [31:0]       p_rdata;
	// Hidden RAM: first layer at 0..H-1, second at H..2H-1
	localparam int HAw = $clog2(2 * HiddenUnits);
	logic              h_we;
	logic [HAw-1:0]    h_addr;
	logic [31:0]       h_wdata;
	logic [31:0]       h_rdata;

	logic        div_start;
	logic        div_done;
	logic signed [31:0] div_quot;

	logic [CntW-1:0] n_in;
	logic [CntW-1:0] n_units;
	logic [15:0]     w_base, b_base, w_addr;
	logic signed [31:0] act_val;
	logic signed [31:0] relu;

	mftp_ram #(.Width(32), .Depth(ParamDepth)) u_param (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(param_value), .rdata(p_rdata)
	);
	mftp_ram #(.Width(32), .Depth(2 * HiddenUnits)) u_hidden (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
	);
	mftp_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(tap_q[fj_q]),
		.den(sum_q), .done(div_done), .quot(div_quot)
	);

	assign busy      = (state_q != StIdle);
	assign cfg_ready = 1'b1;

	// Layer geometry
	always_comb begin
		unique case (layer_q)
			2'd0: begin
				n_in = CntW'(3); n_units = CntW'(HiddenUnits);
				w_base = 16'(W0Base); b_base = 16'(B0Base);
			end
			2'd1: begin
				n_in = CntW'(HiddenUnits); n_units = CntW'(HiddenUnits);
				w_base = 16'(W1Base); b_base = 16'(B1Base);
			end
			default: begin
				n_in = CntW'(HiddenUnits); n_units = CntW'(3);
				w_base = 16'(W2Base); b_base = 16'(B2Base);
			end
		endcase
		w_addr = w_base + 16'(unit_q) * 16'(n_in) + 16'(in_q);
		relu = (acc_q > 0) ? acc_q : 32'sd0;
	end

	// Activation source: features for layer 0, hidden RAM otherwise
	assign act_val = (layer_q == 2'd0) ? feat_q[in_q[1:0]] : h_rdata;

	// RAM addressing
	always_comb begin
		p_we = 1'b0;
		p_addr = AddrW'(param_addr);
		h_we = 1'b0;
		h_addr = '0;
		h_wdata = relu;
		div_start = 1'b0;
		unique case (state_q)
			StIdle: p_we = start && (kind == KindLoad);
			StFeatA: p_addr = AddrW'(MeanBase + 32'(fj_q));
			StFeatB: p_addr = AddrW'(RstdBase + 32'(fj_q));
			StBias: p_addr = AddrW'(16'(b_base + 16'(unit_q)));
			StWt: begin
				p_addr = AddrW'(w_addr);
				h_addr = (layer_q == 2'd2) ? HAw'(HiddenUnits + 32'(in_q))
					: HAw'(in_q);
			end
			StStore: begin
				h_we = (layer_q != 2'd2);
				h_addr = (layer_q == 2'd1) ? HAw'(HiddenUnits + 32'(unit_q))
					: HAw'(unit_q);
			end
			StDiv: div_start = 1'b1;
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StIdle;
			min_gain_q <= MinGainReset;
			strobe     <= 1'b0;
			layer_q    <= '0;
			unit_q     <= '0;
			in_q       <= '0;
			fj_q       <= '0;
		end else begin
			strobe <= 1'b0;
			if (cfg_valid) min_gain_q <= cfg_data;
			unique case (state_q)
				StIdle: if (start && kind == KindPredict) begin
					state_q <= StFeatA;
					fj_q <= '0;
				end
				StFeatA: state_q <= StFeatB;
				StFeatB: state_q <= StFeatC;
				StFeatC: if (fj_q == 2'd2) begin
					state_q <= StBias; layer_q <= '0; unit_q <= '0;
				end else begin
					fj_q <= fj_q + 2'd1; state_q <= StFeatA;
				end
				StBias: state_q <= StBiasW;
				StBiasW: begin state_q <= StWt; in_q <= '0; end
				StWt: state_q <= StMul;
				StMul: state_q <= StAcc;
				StAcc: if (in_q == n_in - CntW'(1)) state_q <= StStore;
				else begin in_q <= in_q + CntW'(1); state_q <= StWt; end
				StStore: if (unit_q == n_units - CntW'(1)) begin
					unit_q <= '0;
					if (layer_q == 2'd2) state_q <= StSum;
					else begin layer_q <= layer_q + 2'd1; state_q <= StBias; end
				end else begin
					unit_q <= unit_q + CntW'(1); state_q <= StBias;
				end
				StSum: if (sum_q > $signed({1'b0, min_gain_q})) begin
					fj_q <= '0; state_q <= StDiv;
				end else state_q <= StOut;
				StDiv: state_q <= StDivW;
				StDivW: if (div_done) begin
					if (fj_q == 2'd2) state_q <= StOut;
					else begin fj_q <= fj_q + 2'd1; state_q <= StDiv; end
				end
				StOut: begin strobe <= 1'b1; state_q <= StIdle; end
				default: state_q <= StIdle;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			StIdle: if (start && kind == KindPredict) begin
				x_q[0] <= centroid; x_q[1] <= level_rms; x_q[2] <= crest;
				norm_q <= 1'b0;
			end
			StFeatB: diff_q <= sat32(64'(x_q[fj_q]) - 64'($signed(p_rdata)));
			StFeatC: feat_q[fj_q] <= qscale(64'(diff_q) * 64'($signed(p_rdata)));
			StBiasW: acc_q <= p_rdata;
			StMul: prod_q <= 64'($signed(p_rdata)) * 64'(act_val);
			StAcc: acc_q <= qadd(acc_q, qscale(prod_q));
			StStore: if (layer_q == 2'd2) tap_q[unit_q[1:0]] <= acc_q;
			StSum: sum_q <= sum_q;
			StDivW: if (div_done) tap_q[fj_q] <= div_quot;
			default: ;
		endcase
		if (state_q == StStore && layer_q == 2'd2 && unit_q == n_units - CntW'(1))
			sum_q <= qadd(qadd(tap_q[0], tap_q[1]), acc_q);
		if (state_q == StSum && sum_q > $signed({1'b0, min_gain_q})) norm_q <= 1'b1;
	end

	assign tap0 = tap_q[0];
	assign tap1 = tap_q[1];
	assign tap2 = tap_q[2];
	assign gain_normalized = norm_q;
endmodule

// File: hw/rtl/mftp_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mftp_ram: generic single-port synchronous RAM
// One write and one read per cycle on the same address, read data registered.
// ---------------------------------------------------------------------------
module mftp_ram #(
	parameter int Width = 32,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Read returns the old word when a write hits the same address
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// File: hw/rtl/mftp_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mftp_divider: radix-2 restoring divider
// Computes sat32(trunc((num * 65536) / den)) for den > 0, one bit a cycle.
// ---------------------------------------------------------------------------
module mftp_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quot
);
	import mftp_pkg::*;

	logic [47:0] dividend_q;
	logic [47:0] quot_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;
	logic signed [63:0] sq;

	assign shifted = {rem_q, dividend_q[47]};
	assign trial   = shifted - {1'b0, den_q};

	// Iterate over 48 numerator bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q      <= num[31];
			dividend_q <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
			den_q      <= den;
			rem_q      <= '0;
			quot_q     <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[46:0], 1'b0};
			if (!trial[32]) begin
				rem_q  <= trial[31:0];
				quot_q <= {quot_q[46:0], 1'b1};
			end else begin
				rem_q  <= shifted[31:0];
				quot_q <= {quot_q[46:0], 1'b0};
			end
		end
	end

	// Sign and saturate
	always_comb begin
		sq = neg_q ? -$signed({16'd0, quot_q}) : $signed({16'd0, quot_q});
		quot = sat32(sq);
	end
endmodule
